// ----- rtl/core/fba_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fba_pkg
// Shared constants, codes and control types of the fit block allocator.
// -----------------------------------------------------------------------------
package fba_pkg;

   // default sizing
   localparam int NUM_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   // fixed field widths of the channels
   localparam int BIDX_W  = 4;
   localparam int BSIZE_W = 16;
   localparam int PID_W   = 16;
   localparam int RSIZE_W = 16;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;
   localparam int BLOCK_COUNT_RST = 16;

   // request kinds
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // placement policies; the unused code behaves as first fit
   typedef logic [1:0] policy_type;
   localparam policy_type FIT_FIRST = 2'd0;
   localparam policy_type FIT_BEST  = 2'd1;
   localparam policy_type FIT_WORST = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // write a block's free size
      logic start;   // capture an allocation request, reset the scan
      logic issue;   // read the next table entry
      logic commit;  // write back the pick and load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;     // entries left to read
      logic pend;     // a read is still being evaluated
      logic rsp_free; // response register can take a new result
   } status_type;

endpackage

// ----- rtl/core/fba_req_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fba_req_if
// Request channel: table loads and allocation requests.
// -----------------------------------------------------------------------------
interface fba_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [fba_pkg::BIDX_W-1:0]  block_index;
   logic [fba_pkg::BSIZE_W-1:0] block_size;
   logic [fba_pkg::PID_W-1:0]   process_id;
   logic [fba_pkg::RSIZE_W-1:0] request_size;

   modport source (output valid, func, block_index, block_size, process_id,
                   request_size, input ready);
   modport sink   (input valid, func, block_index, block_size, process_id,
                   request_size, output ready);
endinterface

// ----- rtl/core/fba_rsp_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fba_rsp_if
// Response channel: outcome of one allocation request.
// -----------------------------------------------------------------------------
interface fba_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fba_pkg::PID_W-1:0] result_id;
   logic                      granted;
   logic [fba_pkg::BIDX_W-1:0] chosen_block;

   modport source (output valid, result_id, granted, chosen_block, input ready);
   modport sink   (input valid, result_id, granted, chosen_block, output ready);
endinterface

// ----- rtl/core/fba_regs.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fba_regs
// Configuration registers; the block count is held already clipped to the
// table depth.
// -----------------------------------------------------------------------------
module fba_regs #(
   parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fba_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output fba_pkg::policy_type               policy,
   output logic [CNT_W-1:0]                  limit
);

   localparam int LIMIT_RST_I = (fba_pkg::BLOCK_COUNT_RST > NUM_BLOCKS) ?
                                NUM_BLOCKS : fba_pkg::BLOCK_COUNT_RST;
   localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(LIMIT_RST_I);

   fba_pkg::policy_type policy_ff, policy_in;
   logic [CNT_W-1:0]    limit_ff, limit_in;

   // register writes
   always_comb begin
      policy_in = policy_ff;
      limit_in  = limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            fba_pkg::CSR_FIT_POLICY: policy_in = csr_wdata[1:0];
            fba_pkg::CSR_BLOCK_COUNT: begin
               if (32'(csr_wdata) > 32'(NUM_BLOCKS)) limit_in = CNT_W'(NUM_BLOCKS);
               else limit_in = CNT_W'(csr_wdata);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fba_pkg::FIT_FIRST;
         limit_ff  <= LIMIT_RST;
      end else begin
         policy_ff <= policy_in;
         limit_ff  <= limit_in;
      end
   end

   assign policy = policy_ff;
   assign limit  = limit_ff;

endmodule

// ----- rtl/core/fba_ctrl.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fba_ctrl
// Sequencer: takes requests, steps the table scan and commits the result.
// -----------------------------------------------------------------------------
module fba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_ready,
   input  fba_pkg::status_type status,
   output fba_pkg::cmd_type    cmd
);

   fba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fba_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         fba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == fba_pkg::FUNC_ALLOC) begin
                  cmd.start = 1'b1;
                  state_in  = fba_pkg::ST_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         fba_pkg::ST_SCAN: begin
            cmd.issue = status.more;
            if (!status.more && !status.pend) state_in = fba_pkg::ST_COMMIT;
         end
         fba_pkg::ST_COMMIT: begin
            // wait until the response register frees up
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = fba_pkg::ST_IDLE;
            end
         end
         default: state_in = fba_pkg::ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/fba_dpath.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fba_dpath
// Free-space table, scan compare/select unit and response register.
// -----------------------------------------------------------------------------
module fba_dpath #(
   parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fba_pkg::SIZE_BITS_DEF,
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fba_pkg::cmd_type              cmd,
   output fba_pkg::status_type           status,
   input  fba_pkg::policy_type           policy,
   input  logic [CNT_W-1:0]              limit,
   input  logic [fba_pkg::BIDX_W-1:0]    req_block_index,
   input  logic [fba_pkg::BSIZE_W-1:0]   req_block_size,
   input  logic [fba_pkg::PID_W-1:0]     req_process_id,
   input  logic [fba_pkg::RSIZE_W-1:0]   req_request_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fba_pkg::PID_W-1:0]     rsp_result_id,
   output logic                          rsp_granted,
   output logic [fba_pkg::BIDX_W-1:0]    rsp_chosen_block
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CMP_W = (SIZE_BITS > fba_pkg::RSIZE_W) ? SIZE_BITS : fba_pkg::RSIZE_W;

   // table storage; valid bits stand in for the cleared reset contents
   logic [SIZE_BITS-1:0]  free_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] vld_ff;

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        pend_ff;
   logic [IDX_W-1:0]            eval_idx_ff;
   logic [SIZE_BITS-1:0]        rd_data_ff;
   logic                        rd_vld_ff;
   logic [fba_pkg::PID_W-1:0]   pid_ff;
   logic [fba_pkg::RSIZE_W-1:0] rsize_ff;
   logic                        found_ff, found_in;
   logic [IDX_W-1:0]            pick_ff, pick_in;
   logic [SIZE_BITS-1:0]        pick_f_ff, pick_f_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [fba_pkg::PID_W-1:0]   rsp_id_ff;
   logic                        rsp_granted_ff;
   logic [fba_pkg::BIDX_W-1:0]  rsp_block_ff;

   logic [SIZE_BITS-1:0] cur_f;
   logic                 fits;
   logic                 take;
   logic                 load_ok;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic                 rsp_fire;

   // compare/select on the entry read last cycle
   always_comb begin
      cur_f = rd_vld_ff ? rd_data_ff : '0;
      fits  = CMP_W'(cur_f) >= CMP_W'(rsize_ff);
      take  = pend_ff && fits &&
              (!found_ff ||
               (policy == fba_pkg::FIT_BEST  && cur_f < pick_f_ff) ||
               (policy == fba_pkg::FIT_WORST && cur_f > pick_f_ff));
      found_in  = found_ff;
      pick_in   = pick_ff;
      pick_f_in = pick_f_ff;
      if (cmd.start) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in  = 1'b1;
         pick_in   = eval_idx_ff;
         pick_f_in = cur_f;
      end
   end

   // scan counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start)      cnt_in = '0;
      else if (cmd.issue) cnt_in = cnt_ff + CNT_W'(1);
   end

   // single table write port: loads in idle, write-back at commit
   always_comb begin
      load_ok = 32'(req_block_index) < 32'(NUM_BLOCKS);
      wr_en   = 1'b0;
      wr_addr = IDX_W'(req_block_index);
      wr_data = SIZE_BITS'(req_block_size);
      if (cmd.load) begin
         wr_en = load_ok;
      end else if (cmd.commit && found_ff) begin
         wr_en   = 1'b1;
         wr_addr = pick_ff;
         wr_data = SIZE_BITS'(CMP_W'(pick_f_ff) - CMP_W'(rsize_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) free_mem[wr_addr] <= wr_data;
      if (cmd.issue) begin
         rd_data_ff  <= free_mem[cnt_ff[IDX_W-1:0]];
         rd_vld_ff   <= vld_ff[cnt_ff[IDX_W-1:0]];
         eval_idx_ff <= cnt_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // response register
   assign rsp_fire = rsp_valid_ff && rsp_ready;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)    rsp_valid_in = 1'b1;
      else if (rsp_fire) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= cmd.issue;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff   <= pick_in;
      pick_f_ff <= pick_f_in;
      if (cmd.start) begin
         pid_ff   <= req_process_id;
         rsize_ff <= req_request_size;
      end
      if (cmd.commit) begin
         rsp_id_ff      <= pid_ff;
         rsp_granted_ff <= found_ff;
         rsp_block_ff   <= found_ff ? fba_pkg::BIDX_W'(pick_ff) : '0;
      end
   end

   assign status.more     = cnt_ff < limit;
   assign status.pend     = pend_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_block_ff;

`ifndef NO_ASSERTIONS
   // a granted block always lies inside the scanned range
   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && found_ff |-> 32'(pick_ff) < 32'(limit))
      else $error("fba_dpath: picked block outside scanned range");

   // a failed request reports block zero
   a_fail_block_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_granted_ff |-> rsp_block_ff == '0)
      else $error("fba_dpath: failed request with nonzero block");

   // a pick is only ever taken on an entry that fits the request
   a_take_fits: assert property (@(posedge clock) disable iff (reset)
      take |=> found_ff && CMP_W'(pick_f_ff) >= CMP_W'(rsize_ff))
      else $error("fba_dpath: pick does not fit request");

   // no new scan starts while a result is still being committed
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !cmd.commit && !pend_ff)
      else $error("fba_dpath: scan started during active request");
`endif

endmodule

// ----- rtl/core/fit_block_allocator.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fit_block_allocator
// Places allocation requests into memory blocks by first, best or worst fit.
// -----------------------------------------------------------------------------
// A load request writes one block's free size and gives no response. An
// allocation request scans the first block_count blocks (clipped to
// NUM_BLOCKS) through the one read port of the free-space table, one entry
// per cycle, then writes back the chosen block; the allocator stays busy
// until the result is loaded into the response register, which may first
// wait for that register to empty. The table reads as all zero after reset
// with no clearing pass. Requests are taken while a finished response still
// waits on the response channel.
module fit_block_allocator #(
   parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fba_pkg::SIZE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   fba_req_if.sink                        req_ch,
   fba_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [fba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fba_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   fba_pkg::policy_type policy;
   logic [CNT_W-1:0]    limit;
   fba_pkg::cmd_type    cmd;
   fba_pkg::status_type status;

   fba_regs #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .policy    (policy),
      .limit     (limit)
   );

   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fba_dpath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .policy           (policy),
      .limit            (limit),
      .req_block_index  (req_ch.block_index),
      .req_block_size   (req_ch.block_size),
      .req_process_id   (req_ch.process_id),
      .req_request_size (req_ch.request_size),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_result_id    (rsp_ch.result_id),
      .rsp_granted      (rsp_ch.granted),
      .rsp_chosen_block (rsp_ch.chosen_block)
   );

endmodule
